@@ rtl/mpe_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpe_pkg
// Shared types and constants of the midpoint ellipse point generator.
// ----------------------------------------------------------------------------
package mpe_pkg;

  // Fixed field widths of the stream words
  localparam int unsigned CORNER_BITS   = 12;
  localparam int unsigned OUT_BITS      = 14;
  localparam int unsigned IN_DATA_BITS  = 4 * CORNER_BITS;
  localparam int unsigned OUT_DATA_BITS = 4 * OUT_BITS;

  // Command codes carried on the input tuser bit
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_NEXT  = 1'b1;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,    // wait for a command
    ST_SQ_RX,   // multiply rx * rx
    ST_SQ_RY,   // multiply ry * ry
    ST_RX2RY,   // multiply rx^2 * ry
    ST_SEED1,   // seed region one
    ST_TX2,     // multiply (2x+1)^2
    ST_RYTX,    // multiply ry^2 * (2x+1)^2
    ST_YM2,     // multiply (y-1)^2
    ST_RXYM,    // multiply rx^2 * (y-1)^2
    ST_RXRY,    // multiply rx^2 * ry^2
    ST_SEED2,   // finish region two seed
    ST_STEP_A,  // emit group, step offsets and slopes
    ST_STEP_B   // finish decision update
  } state_e;

endpackage

@@ rtl/mpe_mul.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpe_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module mpe_mul #(
  parameter int unsigned AW = 29,
  parameter int unsigned BW = 23
) (
  input  logic                      clk_i,
  input  logic signed [AW-1:0]      a_i,
  input  logic signed [BW-1:0]      b_i,
  output logic signed [AW+BW-1:0]   p_o
);

  logic signed [AW+BW-1:0] p_d;
  logic signed [AW+BW-1:0] p_q;

  // Form the full product
  assign p_d = (AW+BW)'(a_i) * (AW+BW)'(b_i);

  // Register the product
  always_ff @(posedge clk_i) begin
    p_q <= p_d;
  end

  assign p_o = p_q;

endmodule

@@ rtl/midpoint_ellipse_point_generator_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midpoint_ellipse_point_generator_core
// Two-region midpoint ellipse outline generator, one group of four mirrored
// points per next command.
// ----------------------------------------------------------------------------
// A start word (tuser = 0) takes two bounding corners, forms the floored
// centre and radii of at least 1, and seeds the outline; it returns no word
// and the port is ready again after states SQ_RX to SEED1. Each next word
// (tuser = 1) returns one result word of four points, with tlast on the
// final group; a further word can be taken in ST_STEP_B, after ST_STEP_A
// has passed its group to a free output, the decision update being split
// over the single wide adder in two steps. The one next word that crosses
// into region two first runs its seed through the shared multiplier for
// five products. A next word taken while no ellipse is active returns nothing.
// ----------------------------------------------------------------------------
module midpoint_ellipse_point_generator_core #(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // corner_a_x, corner_a_y, corner_b_x, corner_b_y
  input  logic [mpe_pkg::IN_DATA_BITS-1:0]    s_axis_tdata_i,
  // command
  input  logic                                s_axis_tuser_i,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // right_x, left_x, lower_y, upper_y
  output logic [mpe_pkg::OUT_DATA_BITS-1:0]   m_axis_tdata_o,
  // done_res
  output logic                                m_axis_tlast_o,
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i
);

  localparam int unsigned CB  = mpe_pkg::CORNER_BITS;
  localparam int unsigned OB  = mpe_pkg::OUT_BITS;
  localparam int unsigned R   = COORD_BITS - 1;    // radius bits
  localparam int unsigned SQW = 2 * R;             // radius squared bits
  localparam int unsigned OW  = R + 2;             // signed offset bits
  localparam int unsigned SW  = 3 * R + 4;         // signed slope bits
  localparam int unsigned DW  = 4 * R + 6;         // signed decision bits
  localparam int unsigned AW  = 2 * R + 7;         // multiplier operand a
  localparam int unsigned BW  = 2 * R + 1;         // multiplier operand b
  localparam int unsigned PW  = AW + BW;
  localparam int unsigned OUT_DATA_BITS_L = mpe_pkg::OUT_DATA_BITS;

  mpe_pkg::state_e state_q, state_d;

  // control
  logic active_q, active_d;
  logic reg2_q, reg2_d;
  logic out_valid_q, out_valid_d;

  // ellipse state
  logic [COORD_BITS-1:0]  cx_q, cy_q;
  logic [R-1:0]           rx_q, ry_q;
  logic [SQW-1:0]         rxsq_q, rysq_q;
  logic signed [OW-1:0]   ox_q, oy_q;
  logic signed [SW-1:0]   sx_q, sy_q;
  logic signed [DW-1:0]   dec_q;
  logic                   add_sx_q, sub_sy_q;
  logic [OUT_DATA_BITS_L-1:0] out_data_q;
  logic                   out_last_q;

  // handshakes
  logic s_acc, is_start, out_free;
  assign s_acc    = s_axis_tvalid_i && s_axis_tready_o;
  assign is_start = (s_axis_tuser_i == mpe_pkg::CMD_START);
  assign out_free = !out_valid_q || m_axis_tready_i;

  // corners trimmed to the coordinate width
  logic [COORD_BITS-1:0] ax, ay, bx, by;
  assign ax = COORD_BITS'(s_axis_tdata_i[CB-1:0]);
  assign ay = COORD_BITS'(s_axis_tdata_i[2*CB-1:CB]);
  assign bx = COORD_BITS'(s_axis_tdata_i[3*CB-1:2*CB]);
  assign by = COORD_BITS'(s_axis_tdata_i[4*CB-1:3*CB]);

  // sort each axis and form span, radius and centre
  logic [COORD_BITS-1:0] lo_x, hi_x, lo_y, hi_y, span_x, span_y;
  logic [COORD_BITS:0]   sum_x, sum_y;
  logic [R-1:0]          rx_new, ry_new;
  always_comb begin
    lo_x   = (ax < bx) ? ax : bx;
    hi_x   = (ax < bx) ? bx : ax;
    lo_y   = (ay < by) ? ay : by;
    hi_y   = (ay < by) ? by : ay;
    span_x = hi_x - lo_x;
    span_y = hi_y - lo_y;
    sum_x  = {1'b0, lo_x} + {1'b0, hi_x};
    sum_y  = {1'b0, lo_y} + {1'b0, hi_y};
    rx_new = span_x[COORD_BITS-1:1];
    ry_new = span_y[COORD_BITS-1:1];
    if (rx_new == '0) begin
      rx_new = R'(1);
    end
    if (ry_new == '0) begin
      ry_new = R'(1);
    end
  end

  // decision flags of the current step
  logic dec_neg, dec_pos, step_done;
  logic signed [OW:0]   tx;
  logic signed [OW-1:0] ym;
  assign dec_neg   = dec_q[DW-1];
  assign dec_pos   = !dec_neg && (dec_q != '0);
  assign step_done = reg2_q && (oy_q <= 0);
  assign tx        = $signed({ox_q, 1'b1});
  assign ym        = oy_q - OW'(1);

  // shared multiplier
  logic signed [AW-1:0] mul_a;
  logic signed [BW-1:0] mul_b;
  logic signed [PW-1:0] mul_p;

  mpe_mul #(
    .AW (AW),
    .BW (BW)
  ) u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  // select multiplier operands per sequencer step
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      mpe_pkg::ST_SQ_RX: begin
        mul_a = AW'($signed({1'b0, rx_q}));
        mul_b = BW'($signed({1'b0, rx_q}));
      end
      mpe_pkg::ST_SQ_RY: begin
        mul_a = AW'($signed({1'b0, ry_q}));
        mul_b = BW'($signed({1'b0, ry_q}));
      end
      mpe_pkg::ST_RX2RY: begin
        mul_a = AW'($signed({1'b0, rxsq_q}));
        mul_b = BW'($signed({1'b0, ry_q}));
      end
      mpe_pkg::ST_TX2: begin
        mul_a = AW'(tx);
        mul_b = BW'(tx);
      end
      mpe_pkg::ST_RYTX: begin
        mul_a = AW'(mul_p);
        mul_b = BW'($signed({1'b0, rysq_q}));
      end
      mpe_pkg::ST_YM2: begin
        mul_a = AW'(ym);
        mul_b = BW'(ym);
      end
      mpe_pkg::ST_RXYM: begin
        mul_a = AW'(mul_p);
        mul_b = BW'($signed({1'b0, rxsq_q}));
      end
      mpe_pkg::ST_RXRY: begin
        mul_a = AW'($signed({1'b0, rxsq_q}));
        mul_b = BW'($signed({1'b0, rysq_q}));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      mpe_pkg::ST_IDLE, mpe_pkg::ST_STEP_B: begin
        state_d = mpe_pkg::ST_IDLE;
        if (s_acc) begin
          if (is_start) begin
            state_d = mpe_pkg::ST_SQ_RX;
          end else if (!active_q) begin
            state_d = mpe_pkg::ST_IDLE;
          end else if (!reg2_q && (sx_q < sy_q)) begin
            state_d = mpe_pkg::ST_STEP_A;
          end else if (!reg2_q) begin
            state_d = mpe_pkg::ST_TX2;
          end else begin
            state_d = mpe_pkg::ST_STEP_A;
          end
        end
      end
      mpe_pkg::ST_SQ_RX: state_d = mpe_pkg::ST_SQ_RY;
      mpe_pkg::ST_SQ_RY: state_d = mpe_pkg::ST_RX2RY;
      mpe_pkg::ST_RX2RY: state_d = mpe_pkg::ST_SEED1;
      mpe_pkg::ST_SEED1: state_d = mpe_pkg::ST_IDLE;
      mpe_pkg::ST_TX2:   state_d = mpe_pkg::ST_RYTX;
      mpe_pkg::ST_RYTX:  state_d = mpe_pkg::ST_YM2;
      mpe_pkg::ST_YM2:   state_d = mpe_pkg::ST_RXYM;
      mpe_pkg::ST_RXYM:  state_d = mpe_pkg::ST_RXRY;
      mpe_pkg::ST_RXRY:  state_d = mpe_pkg::ST_SEED2;
      mpe_pkg::ST_SEED2: state_d = mpe_pkg::ST_STEP_A;
      mpe_pkg::ST_STEP_A: begin
        state_d = out_free ? mpe_pkg::ST_STEP_B : mpe_pkg::ST_STEP_A;
      end
      default: state_d = mpe_pkg::ST_IDLE;
    endcase
  end

  // control outputs and flags
  always_comb begin
    s_axis_tready_o = (state_q == mpe_pkg::ST_IDLE) || (state_q == mpe_pkg::ST_STEP_B);
    active_d        = active_q;
    reg2_d          = reg2_q;
    out_valid_d     = out_valid_q && !m_axis_tready_i;
    case (state_q)
      mpe_pkg::ST_SEED1: begin
        active_d = 1'b1;
        reg2_d   = 1'b0;
      end
      mpe_pkg::ST_SEED2: begin
        reg2_d = 1'b1;
      end
      mpe_pkg::ST_STEP_A: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          if (step_done) begin
            active_d = 1'b0;
          end
        end
      end
      default: begin
        active_d = active_q;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mpe_pkg::ST_IDLE;
      active_q    <= 1'b0;
      reg2_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      active_q    <= active_d;
      reg2_q      <= reg2_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result word of the current offsets
  logic [OB-1:0] right_x, left_x, lower_y, upper_y;
  assign right_x = OB'(cx_q) + OB'(ox_q);
  assign left_x  = OB'(cx_q) - OB'(ox_q);
  assign lower_y = OB'(cy_q) + OB'(oy_q);
  assign upper_y = OB'(cy_q) - OB'(oy_q);

  // datapath registers
  always_ff @(posedge clk_i) begin
    // capture radii and centre on a start word
    if (s_acc && is_start) begin
      rx_q <= rx_new;
      ry_q <= ry_new;
      cx_q <= sum_x[COORD_BITS:1];
      cy_q <= sum_y[COORD_BITS:1];
    end
    case (state_q)
      mpe_pkg::ST_SQ_RY: begin
        rxsq_q <= mul_p[SQW-1:0];
      end
      mpe_pkg::ST_RX2RY: begin
        rysq_q <= mul_p[SQW-1:0];
      end
      mpe_pkg::ST_SEED1: begin
        ox_q  <= '0;
        oy_q  <= OW'(ry_q);
        sx_q  <= '0;
        sy_q  <= SW'(mul_p) <<< 1;
        dec_q <= DW'({rysq_q, 2'b00}) - (DW'(mul_p) <<< 2) + DW'(rxsq_q);
      end
      mpe_pkg::ST_YM2: begin
        dec_q <= DW'(mul_p);
      end
      mpe_pkg::ST_RXRY: begin
        dec_q <= dec_q + (DW'(mul_p) <<< 2);
      end
      mpe_pkg::ST_SEED2: begin
        dec_q <= dec_q - (DW'(mul_p) <<< 2);
      end
      mpe_pkg::ST_STEP_A: begin
        if (out_free) begin
          out_data_q <= {upper_y, lower_y, left_x, right_x};
          out_last_q <= step_done;
          if (!reg2_q) begin
            // region one: always step x, step y on a non-negative decision
            ox_q     <= ox_q + OW'(1);
            sx_q     <= sx_q + SW'({rysq_q, 1'b0});
            dec_q    <= dec_q + DW'({rysq_q, 2'b00});
            add_sx_q <= 1'b1;
            sub_sy_q <= !dec_neg;
            if (!dec_neg) begin
              oy_q <= oy_q - OW'(1);
              sy_q <= sy_q - SW'({rxsq_q, 1'b0});
            end
          end else begin
            // region two: always step y, step x unless the decision is positive
            oy_q     <= oy_q - OW'(1);
            sy_q     <= sy_q - SW'({rxsq_q, 1'b0});
            dec_q    <= dec_q + DW'({rxsq_q, 2'b00});
            add_sx_q <= !dec_pos;
            sub_sy_q <= 1'b1;
            if (!dec_pos) begin
              ox_q <= ox_q + OW'(1);
              sx_q <= sx_q + SW'({rysq_q, 1'b0});
            end
          end
        end
      end
      mpe_pkg::ST_STEP_B: begin
        dec_q <= dec_q
               + (add_sx_q ? (DW'(sx_q) <<< 2) : DW'(0))
               - (sub_sy_q ? (DW'(sy_q) <<< 2) : DW'(0));
      end
      default: begin
        dec_q <= dec_q;
      end
    endcase
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tlast_o  = out_last_q;

endmodule

@@ rtl/mpe_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpe_checker
// Port-level checks of the midpoint ellipse point generator, bound to the
// top level.
// ----------------------------------------------------------------------------
module mpe_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic [mpe_pkg::IN_DATA_BITS-1:0]    s_axis_tdata_i,
  input logic                                s_axis_tuser_i,
  input logic                                s_axis_tvalid_i,
  input logic                                s_axis_tready_o,
  input logic [mpe_pkg::OUT_DATA_BITS-1:0]   m_axis_tdata_o,
  input logic                                m_axis_tlast_o,
  input logic                                m_axis_tvalid_o,
  input logic                                m_axis_tready_i
);

  logic start_acc;
  assign start_acc = s_axis_tvalid_i && s_axis_tready_o
                     && (s_axis_tuser_i == mpe_pkg::CMD_START);

  // hold a stalled result word
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))
    else $error("stalled result word changed");

  // a start word keeps the port busy while the seed is formed
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_acc |=> !s_axis_tready_o)
    else $error("word taken during seed setup");

  // a start word returns no word
  a_start_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_acc |=> !$rose(m_axis_tvalid_o))
    else $error("start word produced a result");

endmodule

bind midpoint_ellipse_point_generator_core mpe_checker u_mpe_checker (.*);

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stream-level testbench of the midpoint ellipse point generator core.
// ----------------------------------------------------------------------------
// Drives start and next words into the slave port and drains point groups
// from the master port, with random gaps on both sides. A tracker class keeps
// its own copy of the outline state, predicts each point group as its command
// word is taken, and checks every result word field by field. A short
// directed part covers idle next words, radius clamping, reversed and full
// canvas corners, and restarts mid-outline. Random outlines follow, mostly
// small and run to completion, with some abandoned ones and loose words.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned STIM_ITEMS     = 850;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES   = 20;
  localparam int unsigned MAX_GAP        = 11;

  localparam int unsigned CORNER_BITS    = mpe_pkg::CORNER_BITS;
  localparam int unsigned OUT_BITS       = mpe_pkg::OUT_BITS;
  localparam int unsigned IN_DATA_BITS   = mpe_pkg::IN_DATA_BITS;
  localparam int unsigned OUT_DATA_BITS  = mpe_pkg::OUT_DATA_BITS;

  // Outline tracker: predicts point groups and checks the returned words
  class ellipse_point_tracker;
    typedef struct {
      logic signed [OUT_BITS-1:0] right_x;
      logic signed [OUT_BITS-1:0] left_x;
      logic signed [OUT_BITS-1:0] lower_y;
      logic signed [OUT_BITS-1:0] upper_y;
      logic                       done;
    } point_group_t;

    // 64-bit working copies; wide enough that every term stays exact
    bit [63:0]    centre_x, centre_y;
    bit [63:0]    rx_sq, ry_sq;
    bit [63:0]    slope_x, slope_y;
    bit [63:0]    dec4;
    longint       off_x, off_y;
    bit           region_two;
    bit           running;
    point_group_t groups_due[$];
    int unsigned  errors;

    // Queue the four mirrored points of the current offsets
    function void push_group(bit last);
      point_group_t g;
      bit [63:0]    ox, oy, rx_sum, lx_sum, ly_sum, uy_sum;
      ox = off_x;
      oy = off_y;
      rx_sum = centre_x + ox;
      lx_sum = centre_x - ox;
      ly_sum = centre_y + oy;
      uy_sum = centre_y - oy;
      g.right_x = rx_sum[OUT_BITS-1:0];
      g.left_x  = lx_sum[OUT_BITS-1:0];
      g.lower_y = ly_sum[OUT_BITS-1:0];
      g.upper_y = uy_sum[OUT_BITS-1:0];
      g.done    = last;
      groups_due = {groups_due, g};
    endfunction

    // Advance the outline by one taken command word
    function void take_command(logic cmd, logic [IN_DATA_BITS-1:0] data);
      bit [63:0] ax, ay, bx, by, lo_x, hi_x, lo_y, hi_y, rx, ry, tx, ym;
      bit        positive, last;
      if (cmd == mpe_pkg::CMD_START) begin
        ax = 64'(data[CORNER_BITS-1:0]);
        ay = 64'(data[2*CORNER_BITS-1:CORNER_BITS]);
        bx = 64'(data[3*CORNER_BITS-1:2*CORNER_BITS]);
        by = 64'(data[4*CORNER_BITS-1:3*CORNER_BITS]);
        lo_x = (ax < bx) ? ax : bx;
        hi_x = (ax < bx) ? bx : ax;
        lo_y = (ay < by) ? ay : by;
        hi_y = (ay < by) ? by : ay;
        rx = (hi_x - lo_x) >> 1;
        ry = (hi_y - lo_y) >> 1;
        if (rx < 64'd1) rx = 64'd1;
        if (ry < 64'd1) ry = 64'd1;
        centre_x   = (lo_x + hi_x) >> 1;
        centre_y   = (lo_y + hi_y) >> 1;
        rx_sq      = rx * rx;
        ry_sq      = ry * ry;
        off_x      = 0;
        off_y      = longint'(ry);
        slope_x    = 64'd0;
        slope_y    = 64'd2 * rx_sq * ry;
        dec4       = 64'd4 * ry_sq - 64'd4 * rx_sq * ry + rx_sq;
        region_two = 1'b0;
        running    = 1'b1;
        return;
      end
      // Drop next words while no outline is in progress
      if (!running) return;
      if (!region_two) begin
        if (slope_x < slope_y) begin
          push_group(1'b0);
          off_x   += 1;
          slope_x += 64'd2 * ry_sq;
          if (dec4[63]) begin
            dec4 += 64'd4 * (ry_sq + slope_x);
          end else begin
            off_y   -= 1;
            slope_y -= 64'd2 * rx_sq;
            dec4    += 64'd4 * (ry_sq + slope_x) - 64'd4 * slope_y;
          end
          return;
        end
        // Region one finished: reseed the decision for region two
        tx = 2 * off_x + 1;
        ym = off_y - 1;
        dec4 = ry_sq * tx * tx - 64'd4 * rx_sq * ry_sq + 64'd4 * rx_sq * ym * ym;
        region_two = 1'b1;
      end
      last     = (off_y <= 0);
      positive = !dec4[63] && (dec4 != 64'd0);
      push_group(last);
      off_y   -= 1;
      slope_y -= 64'd2 * rx_sq;
      if (positive) begin
        dec4 += 64'd4 * rx_sq - 64'd4 * slope_y;
      end else begin
        off_x   += 1;
        slope_x += 64'd2 * ry_sq;
        dec4    += 64'd4 * rx_sq - 64'd4 * slope_y + 64'd4 * slope_x;
      end
      if (off_y < 0) running = 1'b0;
    endfunction

    function void compare_field(string name, logic signed [OUT_BITS-1:0] want,
                                logic signed [OUT_BITS-1:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    // Check one returned word against the oldest predicted group
    function void check_group(logic [OUT_DATA_BITS-1:0] data, logic last);
      point_group_t want;
      if (groups_due.size() == 0) begin
        $error("point group with none predicted: data %h, tlast %b", data, last);
        errors++;
        return;
      end
      want = groups_due.pop_front();
      compare_field("right_x", want.right_x, data[OUT_BITS-1:0]);
      compare_field("left_x",  want.left_x,  data[2*OUT_BITS-1:OUT_BITS]);
      compare_field("lower_y", want.lower_y, data[3*OUT_BITS-1:2*OUT_BITS]);
      compare_field("upper_y", want.upper_y, data[4*OUT_BITS-1:3*OUT_BITS]);
      compare_field("done_res", {{(OUT_BITS-1){1'b0}}, want.done},
                    {{(OUT_BITS-1){1'b0}}, last});
    endfunction
  endclass

  logic                     clk    = 1'b0;
  logic                     rst_n  = 1'b0;
  logic [IN_DATA_BITS-1:0]  s_tdata  = '0;
  logic                     s_tuser  = mpe_pkg::CMD_START;
  logic                     s_tvalid = 1'b0;
  logic                     s_axis_tready_o;
  logic [OUT_DATA_BITS-1:0] m_axis_tdata_o;
  logic                     m_axis_tlast_o;
  logic                     m_axis_tvalid_o;
  logic                     m_tready = 1'b0;

  ellipse_point_tracker tracker = new();
  int unsigned          words_sent;
  int unsigned          quiet_cycles;
  bit                   src_bursty;
  bit                   sink_bursty;

  midpoint_ellipse_point_generator_core i_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_tready)
  );

  // Free-running clock
  initial begin
    forever #2 clk = ~clk;
  end

  function automatic logic [IN_DATA_BITS-1:0] rand_word();
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    return r[IN_DATA_BITS-1:0];
  endfunction

  // Offer one command word after a random gap and hold it until taken
  task automatic send_word(logic cmd, logic [IN_DATA_BITS-1:0] data);
    int unsigned gap;
    gap = src_bursty ? $urandom_range(0, MAX_GAP) : 0;
    if ($urandom_range(0, 39) == 0) src_bursty = !src_bursty;
    repeat (gap) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= data;
    do @(posedge clk); while (s_axis_tready_o !== 1'b1);
    tracker.take_command(cmd, data);
    words_sent++;
  endtask

  // Start an outline: a placed box of bounded span, or any two corners
  task automatic start_ellipse(int unsigned max_span, bit full_range);
    logic [CORNER_BITS-1:0] ax, ay, bx, by;
    int unsigned            sx, sy;
    if (full_range) begin
      ax = CORNER_BITS'($urandom());
      ay = CORNER_BITS'($urandom());
      bx = CORNER_BITS'($urandom());
      by = CORNER_BITS'($urandom());
    end else begin
      sx = $urandom_range(0, max_span);
      sy = $urandom_range(0, max_span);
      ax = CORNER_BITS'($urandom_range(0, 4095 - sx));
      ay = CORNER_BITS'($urandom_range(0, 4095 - sy));
      bx = CORNER_BITS'(ax + sx);
      by = CORNER_BITS'(ay + sy);
      if ($urandom_range(0, 1)) begin
        ax = CORNER_BITS'(ax + sx);
        bx = CORNER_BITS'(bx - sx);
      end
      if ($urandom_range(0, 1)) begin
        ay = CORNER_BITS'(ay + sy);
        by = CORNER_BITS'(by - sy);
      end
    end
    send_word(mpe_pkg::CMD_START, {by, bx, ay, ax});
  endtask

  // Step the outline until done or the cap, then a few idle next words
  task automatic step_outline(int unsigned cap, int unsigned extra);
    int unsigned n;
    n = 0;
    while (tracker.running && n < cap) begin
      send_word(mpe_pkg::CMD_NEXT, rand_word());
      n++;
    end
    repeat (extra) send_word(mpe_pkg::CMD_NEXT, rand_word());
  endtask

  // Drain result words with random back-pressure
  initial begin
    int unsigned gap;
    wait (rst_n === 1'b1);
    forever begin
      gap = sink_bursty ? $urandom_range(0, MAX_GAP) : 0;
      if ($urandom_range(0, 39) == 0) sink_bursty = !sink_bursty;
      repeat (gap) begin
        @(negedge clk);
        m_tready <= 1'b0;
      end
      @(negedge clk);
      m_tready <= 1'b1;
      do @(posedge clk); while (m_axis_tvalid_o !== 1'b1);
      tracker.check_group(m_axis_tdata_o, m_axis_tlast_o);
    end
  end

  // Watchdog: give up when neither port moves a word for too long
  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_axis_tready_o === 1'b1) ||
          (m_axis_tvalid_o === 1'b1 && m_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("tb_top: done, errors");
    $finish;
  end

  // Stimulus and end of run
  initial begin
    int unsigned pick;
    src_bursty  = 1'b1;
    sink_bursty = 1'b1;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Next before any start returns nothing
    send_word(mpe_pkg::CMD_NEXT, '1);
    // Degenerate box at the origin: radii clamp to 1, points go negative
    send_word(mpe_pkg::CMD_START, '0);
    step_outline(8, 1);
    // One-pixel box at the far corner, corners given high to low
    send_word(mpe_pkg::CMD_START, {12'hFFE, 12'hFFE, 12'hFFF, 12'hFFF});
    step_outline(8, 1);
    // Full canvas, then restart mid-outline with reversed y corners
    send_word(mpe_pkg::CMD_START, {12'hFFF, 12'hFFF, 12'h000, 12'h000});
    step_outline(3, 0);
    send_word(mpe_pkg::CMD_START, {12'h000, 12'hFFF, 12'hFFF, 12'h000});
    step_outline(2, 0);
    // Small wide ellipse run through both regions to done
    send_word(mpe_pkg::CMD_START, {12'd14, 12'd11, 12'd10, 12'd3});
    step_outline(20, 1);

    // Random outlines, mostly small and complete
    while (words_sent < STIM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        start_ellipse(24, 1'b0);
        step_outline(1000, $urandom_range(0, 2));
      end else if (pick < 78) begin
        start_ellipse(80, 1'b0);
        step_outline(1000, $urandom_range(0, 1));
      end else if (pick < 82) begin
        start_ellipse(0, 1'b1);
        step_outline($urandom_range(1, 30), 0);
      end else if (pick < 90) begin
        start_ellipse(24, 1'b0);
        step_outline($urandom_range(0, 6), 0);
      end else begin
        send_word(1'($urandom_range(0, 1)), rand_word());
      end
    end

    @(negedge clk);
    s_tvalid <= 1'b0;
    while (tracker.groups_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.errors == 0 && tracker.groups_due.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
